// File: hw/rtl/rau_pkg.sv
// Shared types, operation codes and controller states for the rational arithmetic unit.
package rau_pkg;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_RED = 3'd4,
    ACT_CMP = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ORD_LESS  = 2'd0,
    ORD_EQUAL = 2'd1,
    ORD_GREAT = 2'd2
  } order_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] lhs_num;
    logic [31:0] lhs_den;
    logic [31:0] rhs_num;
    logic [31:0] rhs_den;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [31:0] res_den;
    logic        ok;
    logic [1:0]  order;
  } out_beat_t;

  // Multiplier operand selection.
  typedef enum logic [2:0] {
    MS_LD_RD  = 3'd0,  // lhs_den * rhs_den
    MS_LN_RD  = 3'd1,  // lhs_num * rhs_den
    MS_RN_LD  = 3'd2,  // rhs_num * lhs_den
    MS_LN_RN  = 3'd3,  // lhs_num * rhs_num
    MS_LD_RN  = 3'd4,  // lhs_den * rhs_num
    MS_LD_ONE = 3'd5,  // lhs_den passed through
    MS_LN_ONE = 3'd6,  // lhs_num passed through
    MS_RN_ONE = 3'd7   // rhs_num passed through
  } msel_e;

  typedef enum logic [1:0] {
    DST_T0 = 2'd0,
    DST_T1 = 2'd1,
    DST_T2 = 2'd2
  } dst_e;

  typedef enum logic [1:0] {
    DM_GCD = 2'd0,
    DM_NUM = 2'd1,
    DM_DEN = 2'd2
  } dmode_e;

  typedef enum logic [2:0] {
    RK_FAIL = 3'd0,
    RK_ADD  = 3'd1,
    RK_SUB  = 3'd2,
    RK_FRAC = 3'd3,
    RK_RED  = 3'd4,
    RK_CMP  = 3'd5
  } rkind_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_DEN,
    ST_ADD_AN,
    ST_ADD_BN,
    ST_ADD_FIN,
    ST_MUL_N,
    ST_MUL_D,
    ST_DIV_N,
    ST_DIV_D,
    ST_RED_START,
    ST_GCD_WAIT,
    ST_QN_WAIT,
    ST_QD_WAIT,
    ST_CMP_FIN,
    ST_OUT
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load;
    logic       rearm;     // set the overflow-free flag again
    logic       mul_go;
    msel_e      msel;
    dst_e       mul_dst;
    logic       div_go;
    dmode_e     div_mode;
    logic       gcd_init;  // start gcd on operand selected by red_sel
    logic       red_sel;   // 0 lhs, 1 rhs
    logic       red_wb;    // write reduced pair back to operand
    logic       set_res;
    rkind_e     res_kind;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_done;
    logic gcd_zero;   // divisor in gcd reached zero
    logic red_skip;   // selected operand has a zero part
    logic den_eq;
    logic ok_flag;    // sticky overflow-free flag
  } sts_t;

endpackage

// File: hw/rtl/rau_divider.sv
// Radix-2 restoring divider computing 32-bit quotient and remainder, one bit per cycle.
module rau_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);

  logic [31:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[31]} - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quot_q[31]};
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: hw/rtl/rau_datapath.sv
// Operand registers, shared multiplier, shared divider and result register.
module rau_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::in_beat_t in_i,
  input  rau_pkg::cmd_t     cmd_i,
  output rau_pkg::sts_t     sts_o,
  output rau_pkg::out_beat_t res_o
);

  logic [31:0] ln_q, ld_q, rn_q, rd_q;
  logic [31:0] t0_q, t1_q, t2_q;
  logic [31:0] ga_q, gb_q, g_q;
  logic        ok_q;
  rau_pkg::out_beat_t res_q, res_d;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic        div_start;
  logic [31:0] dvd, dvs, quot, rem;
  logic        div_done;
  logic [31:0] sel_n, sel_d;
  logic [32:0] sum;

  always_comb begin
    unique case (cmd_i.msel)
      rau_pkg::MS_LD_RD:  begin ma = ld_q; mb = rd_q; end
      rau_pkg::MS_LN_RD:  begin ma = ln_q; mb = rd_q; end
      rau_pkg::MS_RN_LD:  begin ma = rn_q; mb = ld_q; end
      rau_pkg::MS_LN_RN:  begin ma = ln_q; mb = rn_q; end
      rau_pkg::MS_LD_RN:  begin ma = ld_q; mb = rn_q; end
      rau_pkg::MS_LD_ONE: begin ma = ld_q; mb = 32'd1; end
      rau_pkg::MS_LN_ONE: begin ma = ln_q; mb = 32'd1; end
      rau_pkg::MS_RN_ONE: begin ma = rn_q; mb = 32'd1; end
      default:            begin ma = ld_q; mb = rd_q; end
    endcase
  end

  assign prod  = 64'(ma) * 64'(mb);
  assign sel_n = cmd_i.red_sel ? rn_q : ln_q;
  assign sel_d = cmd_i.red_sel ? rd_q : ld_q;
  assign sum   = {1'b0, t1_q} + {1'b0, t2_q};

  always_comb begin
    case (cmd_i.div_mode)
      rau_pkg::DM_NUM: begin dvd = sel_n; dvs = g_q; end
      rau_pkg::DM_DEN: begin dvd = sel_d; dvs = g_q; end
      default:         begin dvd = ga_q;  dvs = gb_q; end
    endcase
  end
  assign div_start = cmd_i.div_go;

  rau_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      if (cmd_i.load || cmd_i.rearm) ok_q <= 1'b1;
      else if (cmd_i.mul_go && prod[63:32] != 32'd0) ok_q <= 1'b0;
    end
  end

  always_comb begin
    res_d = '0;
    case (cmd_i.res_kind)
      rau_pkg::RK_ADD: begin
        if (!sum[32]) begin
          res_d.res_num = sum[31:0];
          res_d.res_den = t0_q;
          res_d.ok      = 1'b1;
        end
      end
      rau_pkg::RK_SUB: begin
        if (t1_q >= t2_q) begin
          res_d.res_num = t1_q - t2_q;
          res_d.res_den = t0_q;
          res_d.ok      = 1'b1;
        end
      end
      rau_pkg::RK_FRAC: begin
        res_d.res_num = t1_q;
        res_d.res_den = t0_q;
        res_d.ok      = 1'b1;
      end
      rau_pkg::RK_RED: begin
        res_d.res_num = ln_q;
        res_d.res_den = ld_q;
        res_d.ok      = 1'b1;
      end
      rau_pkg::RK_CMP: begin
        res_d.ok = 1'b1;
        if (t1_q == t0_q) res_d.order = rau_pkg::ORD_EQUAL;
        else if (t1_q > t0_q) res_d.order = rau_pkg::ORD_GREAT;
        else res_d.order = rau_pkg::ORD_LESS;
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ln_q  <= in_i.lhs_num;
      ld_q  <= in_i.lhs_den;
      rn_q  <= in_i.rhs_num;
      rd_q  <= in_i.rhs_den;
    end
    if (cmd_i.mul_go) begin
      case (cmd_i.mul_dst)
        rau_pkg::DST_T0: t0_q <= prod[31:0];
        rau_pkg::DST_T1: t1_q <= prod[31:0];
        default:         t2_q <= prod[31:0];
      endcase
    end
    if (cmd_i.gcd_init) begin
      ga_q <= sel_n;
      gb_q <= sel_d;
    end else if (div_done && cmd_i.div_mode == rau_pkg::DM_GCD) begin
      ga_q <= gb_q;
      gb_q <= rem;
      g_q  <= gb_q;
    end
    // The numerator quotient is caught as the denominator division starts.
    if (div_done && cmd_i.div_mode != rau_pkg::DM_GCD) t0_q <= quot;
    if (cmd_i.red_wb) begin
      if (cmd_i.red_sel) begin
        rn_q <= t0_q;
        rd_q <= quot;
      end else begin
        ln_q <= t0_q;
        ld_q <= quot;
      end
    end
    if (cmd_i.set_res) res_q <= res_d;
  end

  assign sts_o.div_done = div_done;
  assign sts_o.gcd_zero = (gb_q == 32'd0);
  assign sts_o.red_skip = (sel_n == 32'd0) || (sel_d == 32'd0);
  assign sts_o.den_eq   = (ld_q == rd_q);
  assign sts_o.ok_flag  = ok_q;
  assign res_o = res_q;

endmodule

// File: hw/rtl/rau_ctrl.sv
// Controller state machine sequencing multiplies, GCD steps and result delivery.
module rau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        action_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rau_pkg::sts_t     sts_i,
  output rau_pkg::cmd_t     cmd_o
);

  rau_pkg::state_e state_q, state_d;
  logic [2:0] act_q, act_d;
  logic       side_q, side_d;  // operand being reduced
  logic       retry_q, retry_d;  // compare fallback active
  logic       ph_q, ph_d;        // 0 start next gcd division, 1 gcd division in progress

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::ST_IDLE;
      act_q   <= '0;
      side_q  <= 1'b0;
      retry_q <= 1'b0;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      side_q  <= side_d;
      retry_q <= retry_d;
      ph_q    <= ph_d;
    end
  end

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    side_d  = side_q;
    retry_d = retry_q;
    ph_d    = ph_q;
    cmd_o   = '0;
    cmd_o.red_sel = side_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      rau_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          act_d   = action_i;
          retry_d = 1'b0;
          side_d  = 1'b0;
          case (action_i) inside
            rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: state_d = rau_pkg::ST_ADD_DEN;
            rau_pkg::ACT_MUL: state_d = rau_pkg::ST_MUL_N;
            rau_pkg::ACT_DIV, rau_pkg::ACT_CMP: state_d = rau_pkg::ST_DIV_N;
            rau_pkg::ACT_RED: state_d = rau_pkg::ST_RED_START;
            default: state_d = rau_pkg::ST_ADD_FIN;
          endcase
        end
      end
      rau_pkg::ST_ADD_DEN: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.msel = sts_i.den_eq ? rau_pkg::MS_LD_ONE : rau_pkg::MS_LD_RD;
        cmd_o.mul_dst = rau_pkg::DST_T0;
        state_d = rau_pkg::ST_ADD_AN;
      end
      rau_pkg::ST_ADD_AN: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.msel = sts_i.den_eq ? rau_pkg::MS_LN_ONE : rau_pkg::MS_LN_RD;
        cmd_o.mul_dst = rau_pkg::DST_T1;
        state_d = rau_pkg::ST_ADD_BN;
      end
      rau_pkg::ST_ADD_BN: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.msel = sts_i.den_eq ? rau_pkg::MS_RN_ONE : rau_pkg::MS_RN_LD;
        cmd_o.mul_dst = rau_pkg::DST_T2;
        state_d = rau_pkg::ST_ADD_FIN;
      end
      rau_pkg::ST_ADD_FIN: begin
        cmd_o.set_res = 1'b1;
        state_d = rau_pkg::ST_OUT;
        if (act_q == rau_pkg::ACT_ADD || act_q == rau_pkg::ACT_SUB) begin
          cmd_o.res_kind = (act_q == rau_pkg::ACT_ADD) ? rau_pkg::RK_ADD : rau_pkg::RK_SUB;
          if (!sts_i.ok_flag) cmd_o.res_kind = rau_pkg::RK_FAIL;
        end else if (act_q == rau_pkg::ACT_MUL || act_q == rau_pkg::ACT_DIV) begin
          cmd_o.res_kind = sts_i.ok_flag ? rau_pkg::RK_FRAC : rau_pkg::RK_FAIL;
        end else if (act_q == rau_pkg::ACT_RED) begin
          cmd_o.res_kind = rau_pkg::RK_RED;
        end else if (act_q == rau_pkg::ACT_CMP) begin
          cmd_o.res_kind = rau_pkg::RK_CMP;
        end else begin
          cmd_o.res_kind = rau_pkg::RK_FAIL;
        end
      end
      rau_pkg::ST_MUL_N: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.msel = rau_pkg::MS_LN_RN;
        cmd_o.mul_dst = rau_pkg::DST_T1;
        state_d = rau_pkg::ST_MUL_D;
      end
      rau_pkg::ST_MUL_D: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.msel = rau_pkg::MS_LD_RD;
        cmd_o.mul_dst = rau_pkg::DST_T0;
        state_d = rau_pkg::ST_ADD_FIN;
      end
      rau_pkg::ST_DIV_N: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.msel = rau_pkg::MS_LN_RD;
        cmd_o.mul_dst = rau_pkg::DST_T1;
        state_d = rau_pkg::ST_DIV_D;
      end
      rau_pkg::ST_DIV_D: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.msel = rau_pkg::MS_LD_RN;
        cmd_o.mul_dst = rau_pkg::DST_T0;
        state_d = (act_q == rau_pkg::ACT_CMP) ? rau_pkg::ST_CMP_FIN : rau_pkg::ST_ADD_FIN;
      end
      rau_pkg::ST_CMP_FIN: begin
        if (sts_i.ok_flag) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_kind = rau_pkg::RK_CMP;
          state_d = rau_pkg::ST_OUT;
        end else if (!retry_q) begin
          cmd_o.rearm = 1'b1;
          retry_d = 1'b1;
          side_d  = 1'b0;
          state_d = rau_pkg::ST_RED_START;
        end else begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_kind = rau_pkg::RK_FAIL;
          state_d = rau_pkg::ST_OUT;
        end
      end
      rau_pkg::ST_RED_START: begin
        if (sts_i.red_skip) begin
          if (act_q == rau_pkg::ACT_CMP && !side_q) begin
            side_d = 1'b1;
          end else if (act_q == rau_pkg::ACT_CMP) begin
            state_d = rau_pkg::ST_DIV_N;
          end else begin
            state_d = rau_pkg::ST_ADD_FIN;
          end
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d = rau_pkg::ST_GCD_WAIT;
        end
      end
      rau_pkg::ST_GCD_WAIT: begin
        cmd_o.div_mode = rau_pkg::DM_GCD;
        if (sts_i.gcd_zero) begin
          cmd_o.div_go = 1'b1;
          cmd_o.div_mode = rau_pkg::DM_NUM;
          state_d = rau_pkg::ST_QN_WAIT;
        end else if (!ph_q) begin
          cmd_o.div_go = 1'b1;
          ph_d = 1'b1;
        end else if (sts_i.div_done) begin
          ph_d = 1'b0;
        end
      end
      rau_pkg::ST_QN_WAIT: begin
        cmd_o.div_mode = rau_pkg::DM_NUM;
        if (sts_i.div_done) begin
          cmd_o.div_go = 1'b1;
          cmd_o.div_mode = rau_pkg::DM_DEN;
          state_d = rau_pkg::ST_QD_WAIT;
        end
      end
      rau_pkg::ST_QD_WAIT: begin
        cmd_o.div_mode = rau_pkg::DM_DEN;
        if (sts_i.div_done) begin
          cmd_o.red_wb = 1'b1;
          if (act_q == rau_pkg::ACT_CMP && !side_q) begin
            side_d = 1'b1;
            state_d = rau_pkg::ST_RED_START;
          end else if (act_q == rau_pkg::ACT_CMP) begin
            state_d = rau_pkg::ST_DIV_N;
          end else begin
            state_d = rau_pkg::ST_ADD_FIN;
          end
        end
      end
      rau_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = rau_pkg::ST_IDLE;
      end
      default: state_d = rau_pkg::ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.gcd_init |=> state_q == rau_pkg::ST_GCD_WAIT)
    else $error("gcd started outside sequence");

endmodule

// File: hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// One input beat carries an action code and two 32-bit fractions; one output
// beat carries the result fraction, an ok flag and a compare order.
// Both channels use valid and ready handshakes. The unit works on one item at
// a time: in_ready_o is high only while it is idle.
// Add, subtract, multiply and divide each use the single shared 32x32
// multiplier once per product.
// Reduce runs Euclid's algorithm on a shared bit-serial divider; each
// remainder step is one division, and two more divisions then divide the
// numerator and the denominator by the GCD. A compare whose cross products
// overflow reduces both operands this way and retries once.
// The result is held in a register while out_valid_o is high; a stalled
// receiver simply keeps the unit in that state until it accepts the beat.
// Reset returns the controller to idle with no result pending.
module rational_arithmetic_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rau_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rau_pkg::out_beat_t out_data_o
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (in_data_i.action),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rau_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (out_data_o)
  );

endmodule
